// ===== src/tqws_pkg.sv =====
// ============================================================================
// tqws_pkg
// Shared types and constants of the two-queue weighted server.
// ============================================================================
`default_nettype none

package tqws_pkg;

    // fixed widths of the item fields and the burst register
    localparam int DATA_W   = 32;
    localparam int BURST_W  = 4;
    localparam int STATUS_W = 2;

    localparam logic [BURST_W-1:0] BURST_RESET = 4'd2;

    // action codes
    localparam logic ACTION_ENQUEUE = 1'b0;
    localparam logic ACTION_SERVE   = 1'b1;

    // queue select codes
    localparam logic QSEL_PREFERRED    = 1'b0;
    localparam logic QSEL_CONVENTIONAL = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== src/two_queue_weighted_server.sv =====
// An accepted input beat passes the update, head read and load steps before
//   its result beat, waiting in load while the previous result is stalled
//   in the output register. The next beat is accepted only after the accept,
//   update, head read and load steps around the registered queue memory reads.
// Reset: asynchronous, active low; clears queue pointers, counts, run counter
//   and output valid, loads the burst register with 2; memories are not cleared.
// ============================================================================
// two_queue_weighted_server
// Weighted server over a preferred and a conventional bounded queue.
// ============================================================================
`default_nettype none

module two_queue_weighted_server #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [tqws_pkg::BURST_W-1:0]          cfg_write_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic                                  queue_select,
    input  logic signed [tqws_pkg::DATA_W-1:0]    value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [tqws_pkg::STATUS_W-1:0]         status,
    output logic signed [tqws_pkg::DATA_W-1:0]    served_value,
    output logic                                  served_preferred,
    output logic signed [tqws_pkg::DATA_W-1:0]    preferred_head,
    output logic signed [tqws_pkg::DATA_W-1:0]    conventional_head,
    output logic                                  preferred_empty,
    output logic                                  conventional_empty
);
    import tqws_pkg::*;

    ctrl_cmd_t cmd;

    // sequencer
    tqws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // queues, run counter and result register
    tqws_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .action             (action),
        .queue_select       (queue_select),
        .value              (value),
        .status             (status),
        .served_value       (served_value),
        .served_preferred   (served_preferred),
        .preferred_head     (preferred_head),
        .conventional_head  (conventional_head),
        .preferred_empty    (preferred_empty),
        .conventional_empty (conventional_empty)
    );

endmodule

`default_nettype wire

// ===== src/tqws_ctrl.sv =====
// ============================================================================
// tqws_ctrl
// Sequencer: takes one beat, runs the queue update, the head read and the
// result load, and owns the output valid flag.
// ============================================================================
`default_nettype none

module tqws_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tqws_pkg::ctrl_cmd_t  cmd
);
    import tqws_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/tqws_datapath.sv =====
// ============================================================================
// tqws_datapath
// Two circular queues in memories, their pointers and counts, the preferred
// run counter, the burst register and the result register.
// ============================================================================
`default_nettype none

module tqws_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tqws_pkg::ctrl_cmd_t                   cmd,
    input  logic                                  cfg_write_en,
    input  logic [tqws_pkg::BURST_W-1:0]          cfg_write_data,
    input  logic                                  action,
    input  logic                                  queue_select,
    input  logic signed [tqws_pkg::DATA_W-1:0]    value,
    output logic [tqws_pkg::STATUS_W-1:0]         status,
    output logic signed [tqws_pkg::DATA_W-1:0]    served_value,
    output logic                                  served_preferred,
    output logic signed [tqws_pkg::DATA_W-1:0]    preferred_head,
    output logic signed [tqws_pkg::DATA_W-1:0]    conventional_head,
    output logic                                  preferred_empty,
    output logic                                  conventional_empty
);
    import tqws_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // queue storage
    logic [DATA_W-1:0] pref_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] conv_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] pref_rd_data_reg;
    logic [DATA_W-1:0] conv_rd_data_reg;

    // captured item
    logic              action_reg;
    logic              qsel_reg;
    logic [DATA_W-1:0] value_reg;

    // control state
    logic [PTR_W-1:0]   pref_rd_ptr_reg, pref_rd_ptr_next;
    logic [PTR_W-1:0]   pref_wr_ptr_reg, pref_wr_ptr_next;
    logic [CNT_W-1:0]   pref_count_reg, pref_count_next;
    logic [PTR_W-1:0]   conv_rd_ptr_reg, conv_rd_ptr_next;
    logic [PTR_W-1:0]   conv_wr_ptr_reg, conv_wr_ptr_next;
    logic [CNT_W-1:0]   conv_count_reg, conv_count_next;
    logic [BURST_W-1:0] run_reg, run_next;
    logic [BURST_W-1:0] burst_reg, burst_next;

    // per-step results held until the result register is free
    status_t           exec_status_reg, exec_status_next;
    logic [DATA_W-1:0] exec_served_reg, exec_served_next;
    logic              exec_served_pref_reg, exec_served_pref_next;

    // result register
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_served_reg;
    logic              out_served_pref_reg;
    logic [DATA_W-1:0] out_pref_head_reg;
    logic [DATA_W-1:0] out_conv_head_reg;
    logic              out_pref_empty_reg;
    logic              out_conv_empty_reg;

    logic pref_push;
    logic conv_push;
    logic pref_has;
    logic conv_has;

    assign pref_has = (pref_count_reg != '0);
    assign conv_has = (conv_count_reg != '0);

    // step decision: push, weighted pop or status only
    always_comb
    begin
        pref_rd_ptr_next      = pref_rd_ptr_reg;
        pref_wr_ptr_next      = pref_wr_ptr_reg;
        pref_count_next       = pref_count_reg;
        conv_rd_ptr_next      = conv_rd_ptr_reg;
        conv_wr_ptr_next      = conv_wr_ptr_reg;
        conv_count_next       = conv_count_reg;
        run_next              = run_reg;
        exec_status_next      = exec_status_reg;
        exec_served_next      = exec_served_reg;
        exec_served_pref_next = exec_served_pref_reg;
        pref_push             = 1'b0;
        conv_push             = 1'b0;
        if (cmd.execute)
        begin
            exec_status_next      = STATUS_OK;
            exec_served_next      = '0;
            exec_served_pref_next = 1'b0;
            if (action_reg == ACTION_ENQUEUE)
            begin
                if (qsel_reg == QSEL_CONVENTIONAL)
                begin
                    if (conv_count_reg == CNT_FULL)
                    begin
                        exec_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        conv_push        = 1'b1;
                        conv_wr_ptr_next = (conv_wr_ptr_reg == PTR_LAST) ? '0
                                           : conv_wr_ptr_reg + 1'b1;
                        conv_count_next  = conv_count_reg + 1'b1;
                    end
                end
                else
                begin
                    if (pref_count_reg == CNT_FULL)
                    begin
                        exec_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        pref_push        = 1'b1;
                        pref_wr_ptr_next = (pref_wr_ptr_reg == PTR_LAST) ? '0
                                           : pref_wr_ptr_reg + 1'b1;
                        pref_count_next  = pref_count_reg + 1'b1;
                    end
                end
            end
            else if (!pref_has && !conv_has)
            begin
                exec_status_next = STATUS_EMPTY;
            end
            else if (pref_has && ((run_reg < burst_reg) || !conv_has))
            begin
                // preferred pop, run counter saturates at the burst limit
                exec_served_next      = pref_rd_data_reg;
                exec_served_pref_next = 1'b1;
                pref_rd_ptr_next      = (pref_rd_ptr_reg == PTR_LAST) ? '0
                                        : pref_rd_ptr_reg + 1'b1;
                pref_count_next       = pref_count_reg - 1'b1;
                if (run_reg < burst_reg)
                begin
                    run_next = run_reg + 1'b1;
                end
            end
            else
            begin
                // conventional pop ends the preferred run
                exec_served_next = conv_rd_data_reg;
                conv_rd_ptr_next = (conv_rd_ptr_reg == PTR_LAST) ? '0
                                   : conv_rd_ptr_reg + 1'b1;
                conv_count_next  = conv_count_reg - 1'b1;
                run_next         = '0;
            end
        end
    end

    // burst register write
    always_comb
    begin
        burst_next = burst_reg;
        if (cfg_write_en)
        begin
            burst_next = cfg_write_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pref_rd_ptr_reg <= '0;
            pref_wr_ptr_reg <= '0;
            pref_count_reg  <= '0;
            conv_rd_ptr_reg <= '0;
            conv_wr_ptr_reg <= '0;
            conv_count_reg  <= '0;
            run_reg         <= '0;
            burst_reg       <= BURST_RESET;
        end
        else
        begin
            pref_rd_ptr_reg <= pref_rd_ptr_next;
            pref_wr_ptr_reg <= pref_wr_ptr_next;
            pref_count_reg  <= pref_count_next;
            conv_rd_ptr_reg <= conv_rd_ptr_next;
            conv_wr_ptr_reg <= conv_wr_ptr_next;
            conv_count_reg  <= conv_count_next;
            run_reg         <= run_next;
            burst_reg       <= burst_next;
        end
    end

    // queue memories, one write and one registered head read each
    always_ff @(posedge clk)
    begin
        if (pref_push)
        begin
            pref_mem[pref_wr_ptr_reg] <= value_reg;
        end
        if (conv_push)
        begin
            conv_mem[conv_wr_ptr_reg] <= value_reg;
        end
        pref_rd_data_reg <= pref_mem[pref_rd_ptr_reg];
        conv_rd_data_reg <= conv_mem[conv_rd_ptr_reg];
    end

    // item capture, step results and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            qsel_reg   <= queue_select;
            value_reg  <= value;
        end
        exec_status_reg      <= exec_status_next;
        exec_served_reg      <= exec_served_next;
        exec_served_pref_reg <= exec_served_pref_next;
        if (cmd.load)
        begin
            out_status_reg      <= exec_status_reg;
            out_served_reg      <= exec_served_reg;
            out_served_pref_reg <= exec_served_pref_reg;
            out_pref_head_reg   <= pref_has ? pref_rd_data_reg : '0;
            out_conv_head_reg   <= conv_has ? conv_rd_data_reg : '0;
            out_pref_empty_reg  <= !pref_has;
            out_conv_empty_reg  <= !conv_has;
        end
    end

    assign status             = out_status_reg;
    assign served_value       = out_served_reg;
    assign served_preferred   = out_served_pref_reg;
    assign preferred_head     = out_pref_head_reg;
    assign conventional_head  = out_conv_head_reg;
    assign preferred_empty    = out_pref_empty_reg;
    assign conventional_empty = out_conv_empty_reg;

endmodule

`default_nettype wire

// ===== src/tqws_checker.sv =====
// ============================================================================
// tqws_checker
// Port-level checks of the two-queue weighted server, bound to the top level.
// ============================================================================
`default_nettype none

module tqws_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [tqws_pkg::STATUS_W-1:0]         status,
    input  logic signed [tqws_pkg::DATA_W-1:0]    served_value,
    input  logic                                  served_preferred,
    input  logic signed [tqws_pkg::DATA_W-1:0]    preferred_head,
    input  logic signed [tqws_pkg::DATA_W-1:0]    conventional_head,
    input  logic                                  preferred_empty,
    input  logic                                  conventional_empty
);
    import tqws_pkg::*;

    // one beat at a time: busy right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on back-to-back cycles");

    // a stalled result beat stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
    else $error("result beat dropped while stalled");

    // an empty queue reports a zero head
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!preferred_empty || preferred_head == '0) &&
                       (!conventional_empty || conventional_head == '0)))
    else $error("empty queue with nonzero head");

    // nothing to serve means both queues empty and no served value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_EMPTY) |->
            (preferred_empty && conventional_empty &&
             served_value == '0 && !served_preferred))
    else $error("empty status inconsistent with queue state");

    // a preferred serve always comes with the ok status code
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && served_preferred) |-> (status == STATUS_OK))
    else $error("preferred serve without ok status");

endmodule

bind two_queue_weighted_server tqws_checker u_tqws_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .served_value       (served_value),
    .served_preferred   (served_preferred),
    .preferred_head     (preferred_head),
    .conventional_head  (conventional_head),
    .preferred_empty    (preferred_empty),
    .conventional_empty (conventional_empty)
);

`default_nettype wire

// ===== sim/two_queue_weighted_server_checker.sv =====
// ============================================================================
// two_queue_weighted_server_checker
// Watches both channels of the weighted server, predicts each result beat from
// the accepted input beats and the burst register, and compares in order.
// ============================================================================

module two_queue_weighted_server_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [tqws_pkg::BURST_W-1:0]          cfg_write_data,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  action,
    input  logic                                  queue_select,
    input  logic signed [tqws_pkg::DATA_W-1:0]    value,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [tqws_pkg::STATUS_W-1:0]         status,
    input  logic signed [tqws_pkg::DATA_W-1:0]    served_value,
    input  logic                                  served_preferred,
    input  logic signed [tqws_pkg::DATA_W-1:0]    preferred_head,
    input  logic signed [tqws_pkg::DATA_W-1:0]    conventional_head,
    input  logic                                  preferred_empty,
    input  logic                                  conventional_empty,
    output int                                    mismatch_count,
    output int                                    pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    import tqws_pkg::*;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  served_value;
        logic                      served_preferred;
        logic signed [DATA_W-1:0]  preferred_head;
        logic signed [DATA_W-1:0]  conventional_head;
        logic                      preferred_empty;
        logic                      conventional_empty;
    } server_result_t;

    // shadow copy of both queues, the run counter and the burst register
    logic signed [DATA_W-1:0]  preferred_fifo[$];
    logic signed [DATA_W-1:0]  conventional_fifo[$];
    logic [BURST_W-1:0]        preferred_streak;
    logic [BURST_W-1:0]        burst_limit;
    server_result_t            awaited_results[$];

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    // push or serve one item against the shadow queues
    function automatic server_result_t next_server_result(
        input logic                     act,
        input logic                     sel,
        input logic signed [DATA_W-1:0] val
    );
        server_result_t res;
        logic           pref_has;
        logic           conv_has;
        res        = '0;
        res.status = STATUS_OK;
        pref_has   = (preferred_fifo.size() != 0);
        conv_has   = (conventional_fifo.size() != 0);
        if (act == ACTION_ENQUEUE) begin
            if (sel == QSEL_CONVENTIONAL) begin
                if (conventional_fifo.size() >= QUEUE_DEPTH)
                    res.status = STATUS_FULL;
                else
                    conventional_fifo.push_back(val);
            end
            else begin
                if (preferred_fifo.size() >= QUEUE_DEPTH)
                    res.status = STATUS_FULL;
                else
                    preferred_fifo.push_back(val);
            end
        end
        else if (!pref_has && !conv_has) begin
            res.status = STATUS_EMPTY;
        end
        else if (pref_has && (preferred_streak < burst_limit || !conv_has)) begin
            res.served_value     = preferred_fifo.pop_front();
            res.served_preferred = 1'b1;
            // run counter saturates at the burst limit
            if (preferred_streak < burst_limit)
                preferred_streak = preferred_streak + 1'b1;
        end
        else begin
            res.served_value = conventional_fifo.pop_front();
            preferred_streak = '0;
        end
        res.preferred_empty    = (preferred_fifo.size() == 0);
        res.conventional_empty = (conventional_fifo.size() == 0);
        res.preferred_head     = res.preferred_empty ? '0 : preferred_fifo[0];
        res.conventional_head  = res.conventional_empty ? '0 : conventional_fifo[0];
        return res;
    endfunction

    // sample config, input beats and result beats at each edge
    always @(posedge clk or negedge rst_n) begin : monitor
        server_result_t got;
        server_result_t want;
        if (!rst_n) begin
            preferred_fifo.delete();
            conventional_fifo.delete();
            awaited_results.delete();
            preferred_streak = '0;
            burst_limit      = BURST_RESET;
            pending_results  = 0;
        end
        else begin
            if (cfg_write_en)
                burst_limit = cfg_write_data;

            if (in_valid && !in_stall)
                awaited_results.push_back(next_server_result(action, queue_select, value));

            if (out_valid && !out_stall) begin
                got.status             = status_t'(status);
                got.served_value       = served_value;
                got.served_preferred   = served_preferred;
                got.preferred_head     = preferred_head;
                got.conventional_head  = conventional_head;
                got.preferred_empty    = preferred_empty;
                got.conventional_empty = conventional_empty;
                if (awaited_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result beat with nothing awaited, status=%0d served=%0d",
                                 $realtime, status, served_value);
                end
                else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  exp st=%0d sv=%0d sp=%0b ph=%0d ch=%0d pe=%0b ce=%0b",
                                     want.status, want.served_value, want.served_preferred,
                                     want.preferred_head, want.conventional_head,
                                     want.preferred_empty, want.conventional_empty);
                            $display("  got st=%0d sv=%0d sp=%0b ph=%0d ch=%0d pe=%0b ce=%0b",
                                     got.status, got.served_value, got.served_preferred,
                                     got.preferred_head, got.conventional_head,
                                     got.preferred_empty, got.conventional_empty);
                        end
                    end
                end
            end
            pending_results = awaited_results.size();
        end
    end

endmodule

// ===== sim/two_queue_weighted_server_tb.sv =====
// ============================================================================
// two_queue_weighted_server_tb
// Drives enqueue and serve beats into the weighted server under changing burst
// limits and idle patterns; the checker beside the block judges every result.
// ============================================================================

module two_queue_weighted_server_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tqws_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 200;

    logic                        clk;
    logic                        rst_n              = 1'b0;
    logic                        cfg_write_en       = 1'b0;
    logic [BURST_W-1:0]          cfg_write_data     = BURST_RESET;
    logic                        in_valid           = 1'b0;
    logic                        in_stall;
    logic                        action             = ACTION_ENQUEUE;
    logic                        queue_select       = QSEL_PREFERRED;
    logic signed [DATA_W-1:0]    value              = '0;
    logic                        out_valid;
    logic                        out_stall          = 1'b0;
    logic [STATUS_W-1:0]         status;
    logic signed [DATA_W-1:0]    served_value;
    logic                        served_preferred;
    logic signed [DATA_W-1:0]    preferred_head;
    logic signed [DATA_W-1:0]    conventional_head;
    logic                        preferred_empty;
    logic                        conventional_empty;

    int mismatch_count;
    int pending_results;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off requests: ticket bumps, stall process loads length
    int hold_ticket = 0;
    int hold_len    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    two_queue_weighted_server #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .queue_select       (queue_select),
        .value              (value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .served_value       (served_value),
        .served_preferred   (served_preferred),
        .preferred_head     (preferred_head),
        .conventional_head  (conventional_head),
        .preferred_empty    (preferred_empty),
        .conventional_empty (conventional_empty)
    );

    two_queue_weighted_server_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .action             (action),
        .queue_select       (queue_select),
        .value              (value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .served_value       (served_value),
        .served_preferred   (served_preferred),
        .preferred_head     (preferred_head),
        .conventional_head  (conventional_head),
        .preferred_empty    (preferred_empty),
        .conventional_empty (conventional_empty),
        .mismatch_count     (mismatch_count),
        .pending_results    (pending_results)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("two_queue_weighted_server verification failed");
            $finish;
        end
    end

    // receiver side: random stall plus requested long hold-offs
    always @(posedge clk)
    begin
        if (hold_ticket != hold_seen)
        begin
            hold_seen = hold_ticket;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // offer one beat after a random gap, return at its accepting edge
    task automatic push_beat(
        input logic                     act,
        input logic                     sel,
        input logic signed [DATA_W-1:0] val
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        queue_select <= sel;
        value        <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait for every awaited result plus latency margin
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_burst(input logic [BURST_W-1:0] burst);
        wait_drained();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= burst;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // random beat biased toward serve by serve_pct, values favor the extremes
    task automatic random_beat(input int serve_pct);
        logic                     act;
        logic signed [DATA_W-1:0] val;
        act = ($urandom_range(0, 99) < serve_pct) ? ACTION_SERVE : ACTION_ENQUEUE;
        case ($urandom_range(0, 7))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = '0;
            3:       val = '1;
            default: val = $urandom;
        endcase
        push_beat(act, 1'($urandom_range(0, 1)), val);
    endtask

    initial
    begin : stimulus
        logic [BURST_W-1:0] burst;
        int                 serve_pct;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty serve, extremes, full preferred queue, burst order
        send_idle_pct = 24;
        recv_idle_pct = 60;
        push_beat(ACTION_SERVE, QSEL_PREFERRED, '0);
        push_beat(ACTION_ENQUEUE, QSEL_PREFERRED, 32'h7FFF_FFFF);
        push_beat(ACTION_ENQUEUE, QSEL_PREFERRED, 32'h8000_0000);
        push_beat(ACTION_ENQUEUE, QSEL_PREFERRED, '0);
        push_beat(ACTION_ENQUEUE, QSEL_PREFERRED, '1);
        for (int k = 0; k < QUEUE_DEPTH - 4; k++)
            push_beat(ACTION_ENQUEUE, QSEL_PREFERRED, $urandom);
        // preferred queue now full, this value is dropped
        push_beat(ACTION_ENQUEUE, QSEL_PREFERRED, 32'h1);
        push_beat(ACTION_ENQUEUE, QSEL_CONVENTIONAL, 32'h8000_0000);
        push_beat(ACTION_ENQUEUE, QSEL_CONVENTIONAL, 32'h7FFF_FFFF);
        push_beat(ACTION_SERVE, QSEL_PREFERRED, '0);
        push_beat(ACTION_SERVE, QSEL_CONVENTIONAL, '1);
        push_beat(ACTION_SERVE, QSEL_PREFERRED, '0);
        push_beat(ACTION_SERVE, QSEL_CONVENTIONAL, '1);
        push_beat(ACTION_SERVE, QSEL_PREFERRED, '0);

        // burst lowered below the current run: conventional goes next
        write_burst(4'd1);
        push_beat(ACTION_SERVE, QSEL_PREFERRED, '0);
        // conventional empty: preferred served, run climbs to the burst limit
        push_beat(ACTION_SERVE, QSEL_PREFERRED, '0);
        push_beat(ACTION_ENQUEUE, QSEL_CONVENTIONAL, 32'h5555_5555);
        push_beat(ACTION_SERVE, QSEL_PREFERRED, '0);

        // random segments over burst settings and idle patterns
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:       burst = 4'd1;
                1:       burst = 4'd15;
                2:       burst = 4'd0;
                3:       burst = 4'($urandom_range(3, 13));
                4:       burst = BURST_RESET;
                default: burst = 4'd15;
            endcase
            write_burst(burst);
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 24;
                    recv_idle_pct = 60;
                end
                1:
                begin
                    send_idle_pct = 60;
                    recv_idle_pct = 24;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            serve_pct = 50;
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // shift the mix so the queues swing between full and empty
                if (n % 40 == 0)
                    serve_pct = 25 * $urandom_range(1, 3);
                // long receiver hold-off while beats keep coming
                if ((seg == 1 || seg == 4) && n == 50)
                begin
                    hold_len = 300;
                    hold_ticket++;
                end
                // sender pauses until everything has come back
                if (seg == 3 && n == 100)
                    wait_drained();
                random_beat(serve_pct);
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("two_queue_weighted_server verification clean");
        else
            $display("two_queue_weighted_server verification failed");
        $finish;
    end

endmodule
